/* src/ppts_pkg.sv */
`default_nettype none

package ppts_pkg;

  localparam int SLOT_W   = 4;
  localparam int TIME_W   = 16;
  localparam int BURST_W  = 16;
  localparam int PRIO_W   = 8;
  localparam int TICK_W   = 32;
  localparam int CFG_W    = 5;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 40;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [0:0] REG_ACTIVE_COUNT = 1'b0;

  typedef struct packed {
    logic              all_done;
    logic              finished;
    logic              switched;
    logic [SLOT_W-1:0] selected_slot;
    logic              selected_valid;
    logic [TICK_W-1:0] tick_time;
  } result_t;

endpackage

`default_nettype wire

/* src/preemptive_priority_tick_scheduler_core.sv */
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser = command, s_tdata = load fields
// m_*       out  m_tvalid/m_tready  m_tdata = one result per tick command
// apb       in   psel/penable       active_count at byte address 0
//
// A load writes the slot memory at the accept edge.
// A tick reads the slot memory once for each of n = min(active_count, MAX_PROCESSES)
// slots through a single priority comparator; a selected slot is then written back.
// Once all slots are done a tick scans nothing and goes straight to EMIT.
// Reset clears counters and slot valid bits; memory contents need no clearing pass.
// A result waiting in m_tdata does not stop loads; the next tick result waits for it.
`default_nettype none

module preemptive_priority_tick_scheduler_core #(
  parameter int MAX_PROCESSES = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [0:0]                        s_tuser,  // command
  // slot, arrival_time, burst_length, priority_level, zero pad
  input  wire logic [ppts_pkg::IN_W-1:0]         s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // tick_time, selected_valid, selected_slot, switched, finished, all_done
  output logic [ppts_pkg::OUT_W-1:0]             m_tdata,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ppts_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [ppts_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ppts_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready
);

  localparam int SW = $clog2(MAX_PROCESSES);
  localparam int NW = (SW + 1 > ppts_pkg::CFG_W) ? SW + 1 : ppts_pkg::CFG_W;
  localparam int XW = (SW > ppts_pkg::SLOT_W) ? SW : ppts_pkg::SLOT_W;
  localparam int WW = ppts_pkg::TIME_W + PRIORITY_BITS + ppts_pkg::BURST_W;
  localparam int RL = ppts_pkg::BURST_W;
  localparam int PH = RL + PRIORITY_BITS;

  typedef enum logic [1:0] {IDLE, SCAN, EMIT} state_t;

  state_t                       state;
  logic [ppts_pkg::CFG_W-1:0]   active_count;
  logic [MAX_PROCESSES-1:0]     vld;
  logic [ppts_pkg::TICK_W-1:0]  tick_counter;
  logic                         run_valid;
  logic [SW-1:0]                run_slot;
  logic [NW-1:0]                completed;
  logic                         running;
  logic [NW-1:0]                ra;
  logic                         pv;
  logic [SW-1:0]                pidx;
  logic                         found;
  logic [SW-1:0]                best;
  logic [PRIORITY_BITS-1:0]     best_pri;
  logic [ppts_pkg::TIME_W-1:0]  best_arr;
  logic [ppts_pkg::BURST_W-1:0] best_rem;

  logic [ppts_pkg::SLOT_W-1:0]  in_slot;
  logic [ppts_pkg::TIME_W-1:0]  in_arr;
  logic [ppts_pkg::BURST_W-1:0] in_burst;
  logic [ppts_pkg::PRIO_W-1:0]  in_pri;
  logic [XW-1:0]                slot_x;
  logic                         slot_ok;
  logic                         s_accept;
  logic                         load_we;
  logic                         out_free;
  logic                         emit_we;
  logic [NW-1:0]                n_eff;
  logic                         issue;

  logic                         ram_we;
  logic [SW-1:0]                ram_waddr;
  logic [WW-1:0]                ram_wdata;
  logic [WW-1:0]                ram_rdata;

  logic [ppts_pkg::TIME_W-1:0]  rd_arr;
  logic [PRIORITY_BITS-1:0]     rd_pri;
  logic [ppts_pkg::BURST_W-1:0] rd_rem;
  logic                         elig;

  logic [ppts_pkg::BURST_W-1:0] rem_dec;
  logic                         fin;
  logic                         sw;
  logic [NW-1:0]                completed_next;
  ppts_pkg::result_t            res;

  assign in_slot  = s_tdata[3:0];
  assign in_arr   = s_tdata[19:4];
  assign in_burst = s_tdata[35:20];
  assign in_pri   = s_tdata[43:36];
  assign slot_x   = XW'(in_slot);
  assign slot_ok  = (XW+1)'(slot_x) < (XW+1)'(MAX_PROCESSES);

  assign s_tready = (state == IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign load_we  = s_accept && (s_tuser[0] == 1'b0) && slot_ok;
  assign out_free = !m_tvalid || m_tready;
  assign emit_we  = (state == EMIT) && out_free && found;

  assign n_eff = (NW'(active_count) > NW'(MAX_PROCESSES)) ? NW'(MAX_PROCESSES)
                                                           : NW'(active_count);
  assign issue = ra < n_eff;

  assign rd_rem = vld[pidx] ? ram_rdata[RL-1:0] : '0;
  assign rd_pri = ram_rdata[PH-1:RL];
  assign rd_arr = ram_rdata[WW-1:PH];
  assign elig   = (ppts_pkg::TICK_W'(rd_arr) <= tick_counter) && (rd_rem != '0);

  assign rem_dec        = best_rem - 1'b1;
  assign fin            = found && (rem_dec == '0);
  assign sw             = found && (!run_valid || (run_slot != best));
  assign completed_next = completed + NW'(fin);

  always_comb begin
    res.tick_time      = tick_counter;
    res.selected_valid = found;
    res.selected_slot  = ppts_pkg::SLOT_W'(best);
    res.switched       = sw;
    res.finished       = fin;
    res.all_done       = completed_next >= n_eff;
  end

  always_comb begin
    if (load_we) begin
      ram_we    = 1'b1;
      ram_waddr = slot_x[SW-1:0];
      ram_wdata = {in_arr, PRIORITY_BITS'(in_pri), in_burst};
    end else begin
      ram_we    = emit_we;
      ram_waddr = best;
      ram_wdata = {best_arr, best_pri, rem_dec};
    end
  end

  ppts_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_PROCESSES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ra[SW-1:0]),
    .rdata (ram_rdata)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ppts_pkg::REG_ACTIVE_COUNT)
                  ? ppts_pkg::APB_DATA_W'(active_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= '0;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == ppts_pkg::REG_ACTIVE_COUNT)) begin
      active_count <= pwdata[ppts_pkg::CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      vld          <= '0;
      tick_counter <= '0;
      run_valid    <= 1'b0;
      run_slot     <= '0;
      completed    <= '0;
      running      <= 1'b0;
      ra           <= '0;
      pv           <= 1'b0;
      found        <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (load_we) begin
            vld[slot_x[SW-1:0]] <= 1'b1;
            tick_counter        <= '0;
            run_valid           <= 1'b0;
            run_slot            <= '0;
            completed           <= '0;
          end else if (s_accept && s_tuser[0]) begin
            found   <= 1'b0;
            best    <= '0;
            ra      <= '0;
            pv      <= 1'b0;
            running <= completed < n_eff;
            state   <= (completed < n_eff) ? SCAN : EMIT;
          end
        end
        SCAN: begin
          if (issue) begin
            ra <= ra + 1'b1;
          end
          pv   <= issue;
          pidx <= ra[SW-1:0];
          if (pv && elig && (!found || (rd_pri < best_pri))) begin
            found    <= 1'b1;
            best     <= pidx;
            best_pri <= rd_pri;
            best_arr <= rd_arr;
            best_rem <= rd_rem;
          end
          if (ra == n_eff) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res;
            if (found) begin
              run_valid <= 1'b1;
              run_slot  <= best;
              completed <= completed_next;
            end
            if (running && (tick_counter != '1)) begin
              tick_counter <= tick_counter + 1'b1;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_completed_bound: assert property (@(posedge clk) disable iff (rst)
    completed <= NW'(MAX_PROCESSES))
    else $error("completed count beyond slot count");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN) |-> !ram_we)
    else $error("slot memory written during scan");

  a_finish_needs_run: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[38]) |-> m_tdata[32])
    else $error("finished without a selected slot");

  a_load_clears_time: assert property (@(posedge clk) disable iff (rst)
    load_we |=> (tick_counter == '0) && (completed == '0))
    else $error("load did not restart the schedule");

endmodule

`default_nettype wire

/* src/ppts_ram.sv */
`default_nettype none

module ppts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } sched_cmd_e;

  typedef struct {
    sched_cmd_e                    cmd;
    logic [ppts_pkg::SLOT_W-1:0]   slot;
    logic [ppts_pkg::TIME_W-1:0]   arrival;
    logic [ppts_pkg::BURST_W-1:0]  burst;
    logic [ppts_pkg::PRIO_W-1:0]   prio;
  } sched_item_t;

  localparam int NUM_SLOTS = 16;
  localparam int RANDOM_ITEMS = 1750;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [ppts_pkg::APB_ADDR_W-1:0] ADDR_ACTIVE_COUNT =
    ppts_pkg::APB_ADDR_W'(4 * ppts_pkg::REG_ACTIVE_COUNT);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [0:0] s_tuser = '0;
  logic [ppts_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [ppts_pkg::OUT_W-1:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ppts_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [ppts_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [ppts_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  // scheduler image
  logic [ppts_pkg::TIME_W-1:0]  arr_tab [NUM_SLOTS];
  logic [ppts_pkg::PRIO_W-1:0]  prio_tab [NUM_SLOTS];
  logic [ppts_pkg::BURST_W-1:0] rem_tab [NUM_SLOTS] = '{default: '0};
  logic [ppts_pkg::TICK_W-1:0]  tick_cnt = '0;
  bit                           run_valid = 1'b0;
  logic [ppts_pkg::SLOT_W-1:0]  run_slot = '0;
  int                           done_cnt = 0;
  logic [ppts_pkg::CFG_W-1:0]   cfg_active = '0;

  sched_item_t       pending_q[$];
  sched_item_t       cur_item;
  ppts_pkg::result_t tick_results_q[$];

  bit s_fire = 1'b0;
  bit m_fire = 1'b0;
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;
  int send_wait = 0;
  int recv_wait = 0;
  int hold_cnt = 0;
  int results_seen = 0;
  int queued_items = 0;
  int errors = 0;
  int cycle_cnt = 0;

  preemptive_priority_tick_scheduler_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  task automatic run_scheduler(input sched_item_t it);
    int n;
    int best;
    bit found;
    logic [ppts_pkg::TICK_W-1:0] now;
    ppts_pkg::result_t r;
    n = (cfg_active > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_active);
    if (it.cmd == CMD_LOAD) begin
      arr_tab[it.slot] = it.arrival;
      rem_tab[it.slot] = it.burst;
      prio_tab[it.slot] = it.prio;
      tick_cnt = '0;
      run_valid = 1'b0;
      run_slot = '0;
      done_cnt = 0;
      return;
    end
    now = tick_cnt;
    found = 1'b0;
    best = 0;
    r = '0;
    if (done_cnt < n) begin
      for (int i = 0; i < n; i++) begin
        if (arr_tab[i] <= now && rem_tab[i] != 0 &&
            (!found || prio_tab[i] < prio_tab[best])) begin
          best = i;
          found = 1'b1;
        end
      end
      if (found) begin
        r.switched = !run_valid || run_slot != ppts_pkg::SLOT_W'(best);
        run_valid = 1'b1;
        run_slot = ppts_pkg::SLOT_W'(best);
        rem_tab[best] = rem_tab[best] - 1'b1;
        if (rem_tab[best] == 0) begin
          r.finished = 1'b1;
          done_cnt++;
        end
      end
      if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
    end
    r.tick_time = now;
    r.selected_valid = found;
    r.selected_slot = found ? ppts_pkg::SLOT_W'(best) : '0;
    r.all_done = done_cnt >= n;
    tick_results_q.push_back(r);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_fire) begin
      if (send_wait > 0) begin
        send_wait--;
        s_tvalid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur_item = pending_q.pop_front();
        s_tuser <= cur_item.cmd;
        s_tdata <= {4'b0, cur_item.prio, cur_item.burst, cur_item.arrival, cur_item.slot};
        s_tvalid <= 1'b1;
        send_wait = send_quiet ? 0 : $urandom_range(0, 17);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else if (m_tready && !m_fire) begin
      m_tready <= 1'b1;
    end else if (recv_wait > 0) begin
      recv_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    ppts_pkg::result_t got;
    ppts_pkg::result_t want;
    s_fire = 1'b0;
    m_fire = 1'b0;
    if (!rst && s_tvalid && s_tready) begin
      run_scheduler(cur_item);
      s_fire = 1'b1;
    end
    if (!rst && m_tvalid && m_tready) begin
      m_fire = 1'b1;
      got = ppts_pkg::result_t'(m_tdata);
      if (tick_results_q.size() == 0) begin
        report_mismatch("result with nothing pending, tick_time", got.tick_time, 0);
      end else begin
        want = tick_results_q.pop_front();
        if (got.tick_time !== want.tick_time)
          report_mismatch("tick_time", got.tick_time, want.tick_time);
        if (got.selected_valid !== want.selected_valid)
          report_mismatch("selected_valid", got.selected_valid, want.selected_valid);
        if (got.selected_slot !== want.selected_slot)
          report_mismatch("selected_slot", got.selected_slot, want.selected_slot);
        if (got.switched !== want.switched)
          report_mismatch("switched", got.switched, want.switched);
        if (got.finished !== want.finished)
          report_mismatch("finished", got.finished, want.finished);
        if (got.all_done !== want.all_done)
          report_mismatch("all_done", got.all_done, want.all_done);
      end
      results_seen++;
      recv_wait = recv_quiet ? 0 : $urandom_range(0, 17);
      if (results_seen == 200 || results_seen == 900) hold_cnt = HOLD_CYCLES;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_active_count(input int value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_ACTIVE_COUNT;
    pwdata <= ppts_pkg::APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_active = ppts_pkg::CFG_W'(value);
    @(posedge clk);
  endtask

  task automatic push_load(input int slot, input int arrival, input int burst, input int prio);
    sched_item_t it;
    it.cmd = CMD_LOAD;
    it.slot = ppts_pkg::SLOT_W'(slot);
    it.arrival = ppts_pkg::TIME_W'(arrival);
    it.burst = ppts_pkg::BURST_W'(burst);
    it.prio = ppts_pkg::PRIO_W'(prio);
    pending_q.push_back(it);
    queued_items++;
  endtask

  task automatic push_ticks(input int count);
    sched_item_t it;
    for (int i = 0; i < count; i++) begin
      it.cmd = CMD_TICK;
      it.slot = ppts_pkg::SLOT_W'($urandom);
      it.arrival = ppts_pkg::TIME_W'($urandom);
      it.burst = ppts_pkg::BURST_W'($urandom);
      it.prio = ppts_pkg::PRIO_W'($urandom);
      pending_q.push_back(it);
      queued_items++;
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || s_tvalid || tick_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int n;
    int need;
    int max_arr;
    int sets;
    int start;
    int r;
    int cnt;
    int a;
    int b;
    int p;

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    write_active_count(0);
    push_ticks(2);
    wait_drained();

    write_active_count(3);
    push_load(0, 0, 2, 5);
    push_load(1, 1, 1, 2);
    push_load(2, 0, 0, 0);
    push_ticks(5);
    push_load(2, 2, 1, 255);
    push_ticks(4);
    wait_drained();

    write_active_count(16);
    push_load(15, 65535, 65535, 0);
    push_load(0, 0, 1, 255);
    push_load(1, 0, 1, 255);
    push_ticks(3);
    wait_drained();

    write_active_count(1);
    push_load(0, 0, 1, 7);
    push_ticks(3);
    wait_drained();

    queued_items = 0;
    while (queued_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 5);
      n = (r == 0) ? 0 : (r == 1) ? 16 : $urandom_range(1, 16);
      write_active_count(n);
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      sets = $urandom_range(2, 4);
      for (int s = 0; s < sets; s++) begin
        if ($urandom_range(0, 9) == 0) begin
          cnt = $urandom_range(4, 12);
          for (int k = 0; k < cnt; k++) begin
            if ($urandom_range(0, 1) != 0) push_ticks(1);
            else push_load($urandom_range(0, 15), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(0, 255));
          end
        end else begin
          need = 0;
          max_arr = 0;
          start = (n > 0) ? $urandom_range(0, n - 1) : 0;
          for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 19);
            a = (r == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12);
            b = (r == 1) ? $urandom_range(0, 65535) : (r == 2) ? 0 : $urandom_range(1, 6);
            p = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
            push_load((start + k) % n, a, b, p);
            need += b;
            if (a > max_arr) max_arr = a;
          end
          need += max_arr;
          if (need > 60) need = 60;
          push_ticks(need + $urandom_range(0, 3));
        end
      end
      wait_drained();
    end

    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    wait_drained();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
